// ----- hdl/framed_message_tx_queue_credit_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the framed message transmit queue checkers.
// ----------------------------------------------------------------------------
`ifndef FRAMED_MESSAGE_TX_QUEUE_CREDIT_UNIT_DEFINES_SVH
`define FRAMED_MESSAGE_TX_QUEUE_CREDIT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FMTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define FMTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/fmtq_pkg.sv -----
// ----------------------------------------------------------------------------
// fmtq_pkg
// Types and constants shared by the framed message transmit queue modules.
// ----------------------------------------------------------------------------
package fmtq_pkg;

  localparam int QUEUE_BYTES = 8192;
  localparam int ADDR_W      = $clog2(QUEUE_BYTES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SLOTS       = 4;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HDR_BYTES   = 4;
  localparam int LEN_W       = 16;
  localparam int TOT_W       = LEN_W + 1;
  localparam int NEED_W      = CNT_W + 2;

  localparam logic [7:0]       DATA_TYPE_RESET = 8'h91;
  localparam logic [CNT_W-1:0] RESERVE_RESET   = CNT_W'(256);

  localparam logic [2:0] REQ_BEGIN   = 3'd0;
  localparam logic [2:0] REQ_PAYLOAD = 3'd1;
  localparam logic [2:0] REQ_PULL    = 3'd2;
  localparam logic [2:0] REQ_CREDIT  = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;
  localparam logic [2:0] REQ_SESSION = 3'd5;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_ROOM    = 2'd1;
  localparam logic [1:0] STAT_NO_PEER = 2'd2;
  localparam logic [1:0] STAT_NOTHING = 2'd3;

  localparam logic CFG_DATA_TYPE = 1'b0;
  localparam logic CFG_RESERVE   = 1'b1;

  typedef struct packed {
    logic [7:0]       data_type;
    logic [CNT_W-1:0] reserve;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       req;
    logic [7:0]       msg_type;
    logic [7:0]       slot;
    logic             slot_ok;
    logic [LEN_W-1:0] length;
    logic [7:0]       payload_byte;
    logic [31:0]      credit;
    logic             peer;
  } cmd_t;

endpackage

// ----- hdl/fmtq_ram.sv -----
// ----------------------------------------------------------------------------
// fmtq_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module fmtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/fmtq_front.sv -----
// ----------------------------------------------------------------------------
// fmtq_front
// Accepts request beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module fmtq_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_req_type,
  input  logic [7:0]            in_msg_type,
  input  logic [7:0]            in_slot,
  input  logic [15:0]           in_length,
  input  logic [7:0]            in_payload_byte,
  input  logic [31:0]           in_credit_bytes,
  input  logic                  in_peer_present,
  output logic                  cmd_valid,
  output fmtq_pkg::cmd_t        cmd,
  input  logic                  cmd_pop
);

  fmtq_pkg::cmd_t fifo_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  fmtq_pkg::cmd_t cls;

  always_comb begin
    cls.req          = in_req_type;
    cls.msg_type     = in_msg_type;
    cls.slot         = in_slot;
    cls.slot_ok      = (32'(in_slot) < 32'(fmtq_pkg::SLOTS));
    cls.length       = in_length;
    cls.payload_byte = in_payload_byte;
    cls.credit       = in_credit_bytes;
    cls.peer         = in_peer_present;
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- hdl/fmtq_back.sv -----
// ----------------------------------------------------------------------------
// fmtq_back
// Executes queued requests against the byte ring and slot counters.
// ----------------------------------------------------------------------------
module fmtq_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fmtq_pkg::cfg_t              cfg,
  input  logic                        cmd_valid,
  input  fmtq_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [7:0]                  out_byte_out,
  output logic                        out_byte_valid,
  output logic [31:0]                 out_drained_count,
  output logic                        out_slot_idle,
  output logic [fmtq_pkg::CNT_W-1:0]  out_room
);

  localparam int AW = fmtq_pkg::ADDR_W;
  localparam int CW = fmtq_pkg::CNT_W;
  localparam int LW = fmtq_pkg::LEN_W;
  localparam int TW = fmtq_pkg::TOT_W;
  localparam int NW = fmtq_pkg::NEED_W;
  localparam int SN = fmtq_pkg::SLOTS;
  localparam int SW = fmtq_pkg::SLOT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_WHDR  = 3'd2;
  localparam logic [2:0] ST_RHDR  = 3'd3;
  localparam logic [2:0] ST_RBYTE = 3'd4;
  localparam logic [2:0] ST_RES   = 3'd5;

  logic [2:0]     state_r, state_nxt;
  fmtq_pkg::cmd_t cur_r, cur_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  comm_r, comm_nxt;
  logic [CW-1:0]  hbs_r, hbs_nxt;
  logic [LW-1:0]  wrem_r, wrem_nxt;
  logic           wopen_r, wopen_nxt;
  logic           peer_r, peer_nxt;
  logic [AW-1:0]  wp_r, wp_nxt;
  logic [7:0]     otype_r, otype_nxt;
  logic [7:0]     oslot_r, oslot_nxt;
  logic [LW-1:0]  olen_r, olen_nxt;
  logic [7:0]     htype_r, htype_nxt;
  logic [7:0]     hslot_r, hslot_nxt;
  logic [LW-1:0]  hlen_r, hlen_nxt;
  logic [31:0]    queued_r [SN];
  logic [31:0]    queued_nxt [SN];
  logic [31:0]    drained_r [SN];
  logic [31:0]    drained_nxt [SN];
  logic [1:0]     rstat_r, rstat_nxt;
  logic [7:0]     rbyte_r, rbyte_nxt;
  logic           rbv_r, rbv_nxt;
  logic [31:0]    rdrn_r, rdrn_nxt;
  logic           ridle_r, ridle_nxt;

  logic           out_valid_r;
  logic [1:0]     out_status_r;
  logic [7:0]     out_byte_r;
  logic           out_bv_r;
  logic [31:0]    out_drn_r;
  logic           out_idle_r;
  logic [CW-1:0]  out_room_r;
  logic           out_load;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;

  logic [AW-1:0]  wbase;
  logic [TW-1:0]  need_beg;
  logic [TW-1:0]  limit;
  logic [TW-1:0]  total;
  logic [TW-1:0]  hbs_inc;
  logic [NW-1:0]  need_room;
  logic [CW-1:0]  room;
  logic [SW-1:0]  cur_idx;

  fmtq_ram #(.WIDTH(8), .DEPTH(fmtq_pkg::QUEUE_BYTES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign wbase    = head_r + comm_r[AW-1:0];
  assign cur_idx  = cur_r.slot[SW-1:0];
  assign need_beg = TW'(comm_r) + TW'(fmtq_pkg::HDR_BYTES) + TW'(cur_r.length);
  assign total    = TW'(fmtq_pkg::HDR_BYTES) + TW'(hlen_r);
  assign hbs_inc  = TW'(hbs_r) + TW'(1);

  always_comb begin
    if (cur_r.msg_type == cfg.data_type) begin
      limit = (TW'(cfg.reserve) < TW'(fmtq_pkg::QUEUE_BYTES)) ?
              TW'(fmtq_pkg::QUEUE_BYTES) - TW'(cfg.reserve) : '0;
    end else begin
      limit = TW'(fmtq_pkg::QUEUE_BYTES);
    end
  end

  always_comb begin
    need_room = NW'(comm_r) + NW'(fmtq_pkg::HDR_BYTES) + NW'(cfg.reserve);
    room = (need_room < NW'(fmtq_pkg::QUEUE_BYTES)) ?
           CW'(NW'(fmtq_pkg::QUEUE_BYTES) - need_room) : '0;
  end

  assign out_load = (state_r == ST_RES) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    comm_nxt  = comm_r;
    hbs_nxt   = hbs_r;
    wrem_nxt  = wrem_r;
    wopen_nxt = wopen_r;
    peer_nxt  = peer_r;
    wp_nxt    = wp_r;
    otype_nxt = otype_r;
    oslot_nxt = oslot_r;
    olen_nxt  = olen_r;
    htype_nxt = htype_r;
    hslot_nxt = hslot_r;
    hlen_nxt  = hlen_r;
    for (int i = 0; i < SN; i++) begin
      queued_nxt[i]  = queued_r[i];
      drained_nxt[i] = drained_r[i];
    end
    rstat_nxt = rstat_r;
    rbyte_nxt = rbyte_r;
    rbv_nxt   = rbv_r;
    rdrn_nxt  = rdrn_r;
    ridle_nxt = ridle_r;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wbase;
    mem_wdata = '0;
    mem_raddr = head_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cur_nxt   = cmd;
          cmd_pop   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rstat_nxt = fmtq_pkg::STAT_NOTHING;
        rbyte_nxt = '0;
        rbv_nxt   = 1'b0;
        rdrn_nxt  = '0;
        ridle_nxt = 1'b0;
        state_nxt = ST_RES;
        unique case (cur_r.req)
          fmtq_pkg::REQ_BEGIN: begin
            if (!peer_r) begin
              rstat_nxt = fmtq_pkg::STAT_NO_PEER;
            end else begin
              wopen_nxt = 1'b0;
              wrem_nxt  = '0;
              if (need_beg > limit) begin
                rstat_nxt = fmtq_pkg::STAT_ROOM;
              end else begin
                rstat_nxt = fmtq_pkg::STAT_DONE;
                otype_nxt = cur_r.msg_type;
                oslot_nxt = cur_r.slot;
                olen_nxt  = cur_r.length;
                wp_nxt    = wbase + AW'(fmtq_pkg::HDR_BYTES);
                cnt_nxt   = '0;
                state_nxt = ST_WHDR;
              end
            end
          end
          fmtq_pkg::REQ_PAYLOAD: begin
            if (wopen_r && (wrem_r != '0)) begin
              rstat_nxt = fmtq_pkg::STAT_DONE;
              mem_we    = 1'b1;
              mem_waddr = wp_r;
              mem_wdata = cur_r.payload_byte;
              wp_nxt    = wp_r + AW'(1);
              wrem_nxt  = wrem_r - LW'(1);
              if (wrem_r == LW'(1)) begin
                comm_nxt  = comm_r + CW'(fmtq_pkg::HDR_BYTES) + CW'(olen_r);
                wopen_nxt = 1'b0;
                if ((otype_r == cfg.data_type) && (32'(oslot_r) < 32'(SN))) begin
                  for (int i = 0; i < SN; i++) begin
                    if (oslot_r[SW-1:0] == SW'(i)) begin
                      queued_nxt[i] = queued_r[i] + 32'(olen_r);
                    end
                  end
                end
              end
            end
          end
          fmtq_pkg::REQ_PULL: begin
            if (peer_r && (comm_r > hbs_r)) begin
              rstat_nxt = fmtq_pkg::STAT_DONE;
              if (hbs_r == '0) begin
                mem_raddr = head_r;
                cnt_nxt   = '0;
                state_nxt = ST_RHDR;
              end else begin
                mem_raddr = head_r + hbs_r[AW-1:0];
                state_nxt = ST_RBYTE;
              end
            end
          end
          fmtq_pkg::REQ_CREDIT: begin
            if (cur_r.slot_ok) begin
              rstat_nxt = fmtq_pkg::STAT_DONE;
              for (int i = 0; i < SN; i++) begin
                if (cur_idx == SW'(i)) begin
                  drained_nxt[i] = (cur_r.credit < drained_r[i]) ?
                                   drained_r[i] - cur_r.credit : '0;
                end
              end
            end
          end
          fmtq_pkg::REQ_QUERY: begin
            if (cur_r.slot_ok) begin
              rstat_nxt = fmtq_pkg::STAT_DONE;
              rdrn_nxt  = drained_r[cur_idx];
              ridle_nxt = (queued_r[cur_idx] == '0);
            end else begin
              ridle_nxt = 1'b1;
            end
          end
          fmtq_pkg::REQ_SESSION: begin
            rstat_nxt = fmtq_pkg::STAT_DONE;
            head_nxt  = '0;
            comm_nxt  = '0;
            hbs_nxt   = '0;
            wrem_nxt  = '0;
            wopen_nxt = 1'b0;
            peer_nxt  = cur_r.peer;
            for (int i = 0; i < SN; i++) begin
              queued_nxt[i]  = '0;
              drained_nxt[i] = '0;
            end
          end
          default: begin
          end
        endcase
      end
      ST_WHDR: begin
        mem_we    = 1'b1;
        mem_waddr = wbase + AW'(cnt_r);
        unique case (cnt_r)
          2'd0:    mem_wdata = otype_r;
          2'd1:    mem_wdata = oslot_r;
          2'd2:    mem_wdata = olen_r[7:0];
          default: mem_wdata = olen_r[15:8];
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_RES;
          if (olen_r == '0) begin
            comm_nxt = comm_r + CW'(fmtq_pkg::HDR_BYTES);
          end else begin
            wopen_nxt = 1'b1;
            wrem_nxt  = olen_r;
          end
        end
      end
      ST_RHDR: begin
        unique case (cnt_r)
          2'd0:    htype_nxt = mem_rdata;
          2'd1:    hslot_nxt = mem_rdata;
          2'd2:    hlen_nxt  = {hlen_r[15:8], mem_rdata};
          default: hlen_nxt  = {mem_rdata, hlen_r[7:0]};
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          mem_raddr = head_r + hbs_r[AW-1:0];
          state_nxt = ST_RBYTE;
        end else begin
          mem_raddr = head_r + AW'(cnt_r) + AW'(1);
        end
      end
      ST_RBYTE: begin
        rbyte_nxt = mem_rdata;
        rbv_nxt   = 1'b1;
        if ((htype_r == cfg.data_type) && (32'(hslot_r) < 32'(SN)) &&
            (hbs_r >= CW'(fmtq_pkg::HDR_BYTES))) begin
          for (int i = 0; i < SN; i++) begin
            if (hslot_r[SW-1:0] == SW'(i)) begin
              drained_nxt[i] = drained_r[i] + 32'd1;
              queued_nxt[i]  = queued_r[i] - 32'd1;
            end
          end
        end
        if (hbs_inc >= total) begin
          head_nxt = head_r + total[AW-1:0];
          comm_nxt = comm_r - total[CW-1:0];
          hbs_nxt  = '0;
        end else begin
          hbs_nxt = hbs_inc[CW-1:0];
        end
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      comm_r      <= '0;
      hbs_r       <= '0;
      wrem_r      <= '0;
      wopen_r     <= 1'b0;
      peer_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SN; i++) begin
        queued_r[i]  <= '0;
        drained_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      comm_r  <= comm_nxt;
      hbs_r   <= hbs_nxt;
      wrem_r  <= wrem_nxt;
      wopen_r <= wopen_nxt;
      peer_r  <= peer_nxt;
      for (int i = 0; i < SN; i++) begin
        queued_r[i]  <= queued_nxt[i];
        drained_r[i] <= drained_nxt[i];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    cnt_r   <= cnt_nxt;
    wp_r    <= wp_nxt;
    otype_r <= otype_nxt;
    oslot_r <= oslot_nxt;
    olen_r  <= olen_nxt;
    htype_r <= htype_nxt;
    hslot_r <= hslot_nxt;
    hlen_r  <= hlen_nxt;
    rstat_r <= rstat_nxt;
    rbyte_r <= rbyte_nxt;
    rbv_r   <= rbv_nxt;
    rdrn_r  <= rdrn_nxt;
    ridle_r <= ridle_nxt;
    if (out_load) begin
      out_status_r <= rstat_r;
      out_byte_r   <= rbyte_r;
      out_bv_r     <= rbv_r;
      out_drn_r    <= rdrn_r;
      out_idle_r   <= ridle_r;
      out_room_r   <= room;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_byte_out      = out_byte_r;
  assign out_byte_valid    = out_bv_r;
  assign out_drained_count = out_drn_r;
  assign out_slot_idle     = out_idle_r;
  assign out_room          = out_room_r;

endmodule

// ----- hdl/framed_message_tx_queue_credit_unit.sv -----
// ----------------------------------------------------------------------------
// framed_message_tx_queue_credit_unit
// Framed message transmit queue with per-slot queued and drained counters.
// ----------------------------------------------------------------------------
// Request beats enter a two-entry queue and are executed one at a time by a
// sequencer around a byte ring with one write port and a registered read. A
// payload, credit, query or session beat goes from idle through execute to
// result; a begin also writes its four header bytes through the one write
// port; a pull also reads one byte, and on the first byte of a message the
// head header is first read back byte by byte. The result register lets the
// next beat be accepted while a result still waits.
module framed_message_tx_queue_credit_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [fmtq_pkg::CNT_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_req_type,
  input  logic [7:0]                        in_msg_type,
  input  logic [7:0]                        in_slot,
  input  logic [15:0]                       in_length,
  input  logic [7:0]                        in_payload_byte,
  input  logic [31:0]                       in_credit_bytes,
  input  logic                              in_peer_present,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [7:0]                        out_byte_out,
  output logic                              out_byte_valid,
  output logic [31:0]                       out_drained_count,
  output logic                              out_slot_idle,
  output logic [fmtq_pkg::CNT_W-1:0]        out_room
);

  fmtq_pkg::cfg_t cfg_r;
  fmtq_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_type <= fmtq_pkg::DATA_TYPE_RESET;
      cfg_r.reserve   <= fmtq_pkg::RESERVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fmtq_pkg::CFG_DATA_TYPE: cfg_r.data_type <= cfg_data[7:0];
        fmtq_pkg::CFG_RESERVE:   cfg_r.reserve   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fmtq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_msg_type     (in_msg_type),
    .in_slot         (in_slot),
    .in_length       (in_length),
    .in_payload_byte (in_payload_byte),
    .in_credit_bytes (in_credit_bytes),
    .in_peer_present (in_peer_present),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  fmtq_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_byte_out      (out_byte_out),
    .out_byte_valid    (out_byte_valid),
    .out_drained_count (out_drained_count),
    .out_slot_idle     (out_slot_idle),
    .out_room          (out_room)
  );

endmodule

// ----- hdl/fmtq_checker.sv -----
// ----------------------------------------------------------------------------
// fmtq_checker
// Port-level checks on the framed message transmit queue results.
// ----------------------------------------------------------------------------
`include "framed_message_tx_queue_credit_unit_defines.svh"

module fmtq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_byte_valid,
  input logic [31:0] out_drained_count,
  input logic [13:0] out_room
);

  `FMTQ_ASSERT_NOW(a_byte_only_done, clk, rst_n, out_valid && out_byte_valid, out_status == fmtq_pkg::STAT_DONE)
  `FMTQ_ASSERT_NOW(a_fail_no_data, clk, rst_n, out_valid && (out_status != fmtq_pkg::STAT_DONE), !out_byte_valid && (out_drained_count == 32'd0))
  `FMTQ_ASSERT_NOW(a_room_bound, clk, rst_n, out_valid, out_room <= 14'd8188)
  `FMTQ_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status))

endmodule

bind framed_message_tx_queue_credit_unit fmtq_checker u_fmtq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_byte_valid    (out_byte_valid),
  .out_drained_count (out_drained_count),
  .out_room          (out_room)
);
